>>> rtl/core/erat_pkg.sv
// shared types and codes for the exact rational unit
`default_nettype none

package erat_pkg;

  // command codes
  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_POW = 3'd4,
    CMD_SQRT = 3'd5,
    CMD_NEG = 3'd6,
    CMD_INV = 3'd7
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_UNDEF = 2'd1,
    ST_APPROX = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_NORM = 7'b0000010,
    S_GCD = 7'b0000100,
    S_DIVN = 7'b0001000,
    S_DIVD = 7'b0010000,
    S_MUL = 7'b0100000,
    S_SQRT = 7'b1000000
  } state_t;

  // which step of the command the sequencer is on
  typedef enum logic [10:0] {
    PH_LA = 11'b00000000001,
    PH_LB = 11'b00000000010,
    PH_M1 = 11'b00000000100,
    PH_M2 = 11'b00000001000,
    PH_M3 = 11'b00000010000,
    PH_PN = 11'b00000100000,
    PH_PD = 11'b00001000000,
    PH_SQN = 11'b00010000000,
    PH_SQD = 11'b00100000000,
    PH_RES = 11'b01000000000,
    PH_PINV = 11'b10000000000
  } phase_t;

endpackage

`default_nettype wire

>>> rtl/core/erat_mul.sv
// bit-serial signed multiplier with word overflow detection
`default_nettype none

module erat_mul #(
  parameter int W = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                go,
  input  wire logic signed [W-1:0] x,
  input  wire logic signed [W-1:0] y,
  output logic                     done,
  output logic signed [W-1:0]      p,
  output logic                     ovf
);

  localparam int CW = $clog2(W + 1);
  localparam logic [W+1:0] LIM = (W + 2)'(1) << (W - 1);

  function automatic logic [W-1:0] mag_f(input logic signed [W-1:0] v);
    mag_f = v[W-1] ? $unsigned(-v) : $unsigned(v);
  endfunction

  logic          run_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  ma_r;
  logic [W-1:0]  mb_r;
  logic [W-1:0]  acc_r;
  logic          ovf_r;
  logic          neg_r;
  logic [W+1:0]  sum;

  // double and add, multiplier bits taken from the top
  always_comb begin
    sum = (W + 2)'({acc_r, 1'b0}) + (mb_r[W-1] ? (W + 2)'(ma_r) : '0);
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= CW'(W);
      end else if (run_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          run_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath; overflow is sticky since the partial product only grows
  always_ff @(posedge clk) begin
    if (go) begin
      ma_r <= mag_f(x);
      mb_r <= mag_f(y);
      acc_r <= '0;
      ovf_r <= 1'b0;
      neg_r <= x[W-1] ^ y[W-1];
    end else if (run_r) begin
      acc_r <= sum[W-1:0];
      mb_r <= {mb_r[W-2:0], 1'b0};
      if (sum > LIM) begin
        ovf_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign p = neg_r ? -$signed(acc_r) : $signed(acc_r);
  assign ovf = ovf_r || (!neg_r && (acc_r == LIM[W-1:0]));

endmodule

`default_nettype wire

>>> rtl/core/erat_div.sv
// restoring unsigned divider, one quotient bit per cycle
`default_nettype none

module erat_div #(
  parameter int W = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         go,
  input  wire logic [W-1:0] n,
  input  wire logic [W-1:0] d,
  output logic              done,
  output logic [W-1:0]      q
);

  localparam int CW = $clog2(W + 1);

  logic          run_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  q_r;
  logic [W-1:0]  d_r;
  logic [W-1:0]  rem_r;
  logic [W:0]    trial;
  logic [W:0]    diff;

  // shift in the next dividend bit and try the subtract
  always_comb begin
    trial = {rem_r, q_r[W-1]};
    diff = trial - {1'b0, d_r};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= CW'(W);
      end else if (run_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          run_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (go) begin
      q_r <= n;
      d_r <= d;
      rem_r <= '0;
    end else if (run_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_r <= diff[W-1:0];
        q_r <= {q_r[W-2:0], 1'b1};
      end else begin
        rem_r <= trial[W-1:0];
        q_r <= {q_r[W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign q = q_r;

endmodule

`default_nettype wire

>>> rtl/core/erat_gcd.sv
// binary gcd engine, one shift or subtract per cycle
`default_nettype none

module erat_gcd #(
  parameter int W = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         go,
  input  wire logic [W-1:0] u,
  input  wire logic [W-1:0] v,
  output logic              done,
  output logic [W-1:0]      g
);

  localparam int KW = $clog2(W);

  logic          run_r;
  logic          done_r;
  logic [W-1:0]  u_r;
  logic [W-1:0]  v_r;
  logic [KW-1:0] k_r;
  logic [W-1:0]  g_r;
  logic          fin;

  assign fin = (u_r == '0) || (v_r == '0);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
      end else if (run_r && fin) begin
        run_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // strip common twos, then subtract the smaller odd value
  always_ff @(posedge clk) begin
    if (go) begin
      u_r <= u;
      v_r <= v;
      k_r <= '0;
    end else if (run_r) begin
      if (fin) begin
        g_r <= (u_r | v_r) << k_r;
      end else if (!u_r[0] && !v_r[0]) begin
        u_r <= u_r >> 1;
        v_r <= v_r >> 1;
        k_r <= k_r + KW'(1);
      end else if (!u_r[0]) begin
        u_r <= u_r >> 1;
      end else if (!v_r[0]) begin
        v_r <= v_r >> 1;
      end else if (u_r >= v_r) begin
        u_r <= u_r - v_r;
      end else begin
        v_r <= v_r - u_r;
      end
    end
  end

  assign done = done_r;
  assign g = g_r;

endmodule

`default_nettype wire

>>> rtl/core/erat_isqrt.sv
// digit-by-digit integer square root with exactness flag
`default_nettype none

module erat_isqrt #(
  parameter int W = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         go,
  input  wire logic [W-1:0] x,
  output logic              done,
  output logic [W-1:0]      root,
  output logic              exact
);

  localparam int ITER = (W + 1) / 2;
  localparam int CW = $clog2(ITER + 1);
  localparam logic [W-1:0] TOPBIT = W'(1) << (2 * (ITER - 1));

  logic          run_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  n_r;
  logic [W-1:0]  r_r;
  logic [W-1:0]  bit_r;
  logic [W-1:0]  t;

  assign t = r_r + bit_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= CW'(ITER);
      end else if (run_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          run_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // one root bit per cycle; n_r ends as the remainder
  always_ff @(posedge clk) begin
    if (go) begin
      n_r <= x;
      r_r <= '0;
      bit_r <= TOPBIT;
    end else if (run_r) begin
      if (n_r >= t) begin
        n_r <= n_r - t;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r;
  assign exact = (n_r == '0);

endmodule

`default_nettype wire

>>> rtl/core/exact_rational_alu_top.sv
// exact rational unit: sequencer over shared multiplier, divider, gcd and root engines
//
// One item (command plus two fractions) is taken when start is high and busy is low;
// the result appears once, for one cycle, with out_strobe, and cannot be held off.
// An item with a bad operand at the ports finishes straight from idle. Otherwise the
// operands are reduced first (gcd then two divisions; a alone for sqrt, neg and inv),
// then add, sub, mul, div and pow run on a single bit-serial multiplier, sqrt on the
// root engine, and the result, except for neg, is reduced the same way. pow takes two
// products per exponent step. The shared engines each retire one bit or one step per
// cycle. busy stays high for the whole item, except one finished straight from idle.
`default_nettype none

module exact_rational_alu_top import erat_pkg::*; #(
  parameter int WORD_BITS = 64,
  parameter int POW_LIMIT = 63
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_cmd,
  input  wire logic signed [63:0] in_a_num,
  input  wire logic [62:0]        in_a_den,
  input  wire logic               in_a_undef,
  input  wire logic signed [63:0] in_b_num,
  input  wire logic [62:0]        in_b_den,
  input  wire logic               in_b_undef,
  output logic                    out_strobe,
  output logic signed [63:0]      out_r_num,
  output logic [62:0]             out_r_den,
  output logic [1:0]              out_status
);

  localparam int W = WORD_BITS;
  localparam int EW = $clog2(POW_LIMIT + 1);
  localparam logic signed [W-1:0] MINV = {1'b1, {(W - 1){1'b0}}};
  localparam logic signed [W-1:0] ONE_W = W'(1);
  localparam logic signed [W-1:0] PLIM = W'(POW_LIMIT);
  localparam logic signed [W-1:0] NLIM = -PLIM;

  function automatic logic [W-1:0] mag_f(input logic signed [W-1:0] v);
    mag_f = v[W-1] ? $unsigned(-v) : $unsigned(v);
  endfunction

  state_t  state_r, state_nxt;
  phase_t  phase_r, phase_nxt;
  cmd_t    cmd_r, cmd_nxt;
  logic signed [W-1:0] an_r, an_nxt, ad_r, ad_nxt;
  logic signed [W-1:0] bn_r, bn_nxt, bd_r, bd_nxt;
  logic signed [W-1:0] t1_r, t1_nxt, t2_r, t2_nxt;
  logic signed [W-1:0] xn_r, xn_nxt, xd_r, xd_nxt;
  logic [W-1:0]        g_r, g_nxt;
  logic [EW-1:0]       e_r, e_nxt;
  logic                pneg_r, pneg_nxt;
  logic                strobe_r, strobe_nxt;
  logic signed [W-1:0] onum_r, onum_nxt, oden_r, oden_nxt;
  status_t             ost_r, ost_nxt;

  // unit handshakes
  logic                mul_go, mul_done, mul_ovf;
  logic signed [W-1:0] mul_x, mul_y, mul_p;
  logic                div_go, div_done;
  logic [W-1:0]        div_n, div_d, div_q;
  logic                gcd_go, gcd_done;
  logic [W-1:0]        gcd_u, gcd_v, gcd_g;
  logic                sq_go, sq_done, sq_exact;
  logic [W-1:0]        sq_x, sq_root;

  // finish request
  logic                fin;
  status_t             fin_st;
  logic signed [W-1:0] fin_n, fin_d;

  // operand screening at the ports
  logic [63:0]         a_d64, b_d64;
  logic                a_undef, b_undef, a_rng, b_rng;
  logic signed [W-1:0] nn, nd, sq_div;
  logic signed [W:0]   sum_w;
  logic                sum_ovf;

  assign a_d64 = {1'b0, in_a_den};
  assign b_d64 = {1'b0, in_b_den};
  assign a_undef = in_a_undef || (in_a_den == '0);
  assign b_undef = in_b_undef || (in_b_den == '0);
  assign a_rng = !((in_a_num[63:W-1] == '0) || (in_a_num[63:W-1] == '1)) ||
                 (a_d64[63:W-1] != '0);
  assign b_rng = !((in_b_num[63:W-1] == '0) || (in_b_num[63:W-1] == '1)) ||
                 (b_d64[63:W-1] != '0);

  // reduced pair coming out of the normalise sequence
  assign nn = xn_r;
  assign nd = $signed(div_q);
  assign sq_div = $signed(sq_root);

  // cross-product sum for add and sub
  assign sum_w = {t1_r[W-1], t1_r} + {mul_p[W-1], mul_p};
  assign sum_ovf = sum_w[W] != sum_w[W-1];

  // sequencer
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd_nxt = cmd_r;
    an_nxt = an_r;
    ad_nxt = ad_r;
    bn_nxt = bn_r;
    bd_nxt = bd_r;
    t1_nxt = t1_r;
    t2_nxt = t2_r;
    xn_nxt = xn_r;
    xd_nxt = xd_r;
    g_nxt = g_r;
    e_nxt = e_r;
    pneg_nxt = pneg_r;
    strobe_nxt = 1'b0;
    onum_nxt = onum_r;
    oden_nxt = oden_r;
    ost_nxt = ost_r;
    mul_go = 1'b0;
    mul_x = an_r;
    mul_y = bd_r;
    div_go = 1'b0;
    div_n = mag_f(xn_r);
    div_d = gcd_g;
    gcd_go = 1'b0;
    gcd_u = mag_f(xn_r);
    gcd_v = mag_f(xd_r);
    sq_go = 1'b0;
    sq_x = $unsigned(an_r);
    fin = 1'b0;
    fin_st = ST_OK;
    fin_n = '0;
    fin_d = ONE_W;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = cmd_t'(in_cmd);
          an_nxt = $signed(in_a_num[W-1:0]);
          ad_nxt = $signed(a_d64[W-1:0]);
          bn_nxt = $signed(in_b_num[W-1:0]);
          bd_nxt = $signed(b_d64[W-1:0]);
          xn_nxt = $signed(in_a_num[W-1:0]);
          xd_nxt = $signed(a_d64[W-1:0]);
          phase_nxt = PH_LA;
          if (in_cmd <= CMD_POW) begin
            if (a_undef || b_undef) begin
              fin = 1'b1;
              fin_st = ST_UNDEF;
            end else if (a_rng || b_rng) begin
              fin = 1'b1;
              fin_st = ST_APPROX;
            end else begin
              state_nxt = S_NORM;
            end
          end else begin
            if (a_undef) begin
              fin = 1'b1;
              fin_st = ST_UNDEF;
            end else if (a_rng) begin
              fin = 1'b1;
              fin_st = ST_APPROX;
            end else begin
              state_nxt = S_NORM;
            end
          end
        end
      end

      // zero denominator check, sign fix, launch gcd
      S_NORM: begin
        if (xd_r == '0) begin
          fin = 1'b1;
          fin_st = ST_UNDEF;
        end else if (xd_r[W-1] && ((xn_r == MINV) || (xd_r == MINV))) begin
          fin = 1'b1;
          fin_st = ST_APPROX;
        end else begin
          if (xd_r[W-1]) begin
            xn_nxt = -xn_r;
            xd_nxt = -xd_r;
          end
          gcd_go = 1'b1;
          state_nxt = S_GCD;
        end
      end

      S_GCD: begin
        if (gcd_done) begin
          g_nxt = gcd_g;
          div_go = 1'b1;
          state_nxt = S_DIVN;
        end
      end

      S_DIVN: begin
        div_n = $unsigned(xd_r);
        div_d = g_r;
        if (div_done) begin
          xn_nxt = xn_r[W-1] ? -$signed(div_q) : $signed(div_q);
          div_go = 1'b1;
          state_nxt = S_DIVD;
        end
      end

      // reduced pair ready: move on according to the step
      S_DIVD: begin
        if (div_done) begin
          xd_nxt = nd;
          case (phase_r)
            PH_LA: begin
              an_nxt = nn;
              ad_nxt = nd;
              if (cmd_r <= CMD_POW) begin
                xn_nxt = bn_r;
                xd_nxt = bd_r;
                phase_nxt = PH_LB;
                state_nxt = S_NORM;
              end else begin
                case (cmd_r)
                  CMD_SQRT: begin
                    if (nn[W-1]) begin
                      fin = 1'b1;
                      fin_st = ST_UNDEF;
                    end else begin
                      sq_go = 1'b1;
                      sq_x = $unsigned(nn);
                      phase_nxt = PH_SQN;
                      state_nxt = S_SQRT;
                    end
                  end
                  CMD_NEG: begin
                    fin = 1'b1;
                    if (nn == MINV) begin
                      fin_st = ST_APPROX;
                    end else begin
                      fin_n = -nn;
                      fin_d = nd;
                    end
                  end
                  default: begin
                    xn_nxt = nd;
                    xd_nxt = nn;
                    phase_nxt = PH_RES;
                    state_nxt = S_NORM;
                  end
                endcase
              end
            end
            PH_LB: begin
              bn_nxt = nn;
              bd_nxt = nd;
              mul_x = an_r;
              mul_y = nd;
              phase_nxt = PH_M1;
              case (cmd_r)
                CMD_ADD: begin
                  mul_go = 1'b1;
                  state_nxt = S_MUL;
                end
                CMD_SUB: begin
                  if (nn == MINV) begin
                    fin = 1'b1;
                    fin_st = ST_APPROX;
                  end else begin
                    bn_nxt = -nn;
                    mul_go = 1'b1;
                    state_nxt = S_MUL;
                  end
                end
                CMD_MUL: begin
                  mul_y = nn;
                  mul_go = 1'b1;
                  state_nxt = S_MUL;
                end
                CMD_DIV: begin
                  if (nn == '0) begin
                    fin = 1'b1;
                    fin_st = ST_UNDEF;
                  end else begin
                    mul_go = 1'b1;
                    state_nxt = S_MUL;
                  end
                end
                default: begin
                  if ((nd != ONE_W) || (nn > PLIM) || (nn < NLIM)) begin
                    fin = 1'b1;
                    fin_st = (an_r[W-1] && (nd != ONE_W)) ? ST_UNDEF : ST_APPROX;
                  end else if (nn == '0) begin
                    fin = 1'b1;
                    fin_n = ONE_W;
                  end else begin
                    e_nxt = EW'(mag_f(nn));
                    pneg_nxt = nn[W-1];
                    t2_nxt = ONE_W;
                    mul_x = ONE_W;
                    mul_y = an_r;
                    mul_go = 1'b1;
                    phase_nxt = PH_PN;
                    state_nxt = S_MUL;
                  end
                end
              endcase
            end
            PH_RES: begin
              if ((cmd_r == CMD_POW) && pneg_r) begin
                xn_nxt = nd;
                xd_nxt = nn;
                phase_nxt = PH_PINV;
                state_nxt = S_NORM;
              end else begin
                fin = 1'b1;
                fin_n = nn;
                fin_d = nd;
              end
            end
            PH_PINV: begin
              fin = 1'b1;
              fin_n = nn;
              fin_d = nd;
            end
            default: begin
              fin = 1'b1;
              fin_st = ST_APPROX;
            end
          endcase
        end
      end

      // product ready
      S_MUL: begin
        if (mul_done) begin
          if (mul_ovf) begin
            fin = 1'b1;
            fin_st = ST_APPROX;
          end else begin
            case (phase_r)
              PH_M1: begin
                t1_nxt = mul_p;
                mul_go = 1'b1;
                phase_nxt = PH_M2;
                case (cmd_r)
                  CMD_MUL: begin
                    mul_x = ad_r;
                    mul_y = bd_r;
                  end
                  CMD_DIV: begin
                    mul_x = ad_r;
                    mul_y = bn_r;
                  end
                  default: begin
                    mul_x = bn_r;
                    mul_y = ad_r;
                  end
                endcase
              end
              PH_M2: begin
                if ((cmd_r == CMD_ADD) || (cmd_r == CMD_SUB)) begin
                  if (sum_ovf) begin
                    fin = 1'b1;
                    fin_st = ST_APPROX;
                  end else begin
                    t1_nxt = sum_w[W-1:0];
                    mul_x = ad_r;
                    mul_y = bd_r;
                    mul_go = 1'b1;
                    phase_nxt = PH_M3;
                  end
                end else begin
                  xn_nxt = t1_r;
                  xd_nxt = mul_p;
                  phase_nxt = PH_RES;
                  state_nxt = S_NORM;
                end
              end
              PH_M3: begin
                xn_nxt = t1_r;
                xd_nxt = mul_p;
                phase_nxt = PH_RES;
                state_nxt = S_NORM;
              end
              PH_PN: begin
                t1_nxt = mul_p;
                mul_x = t2_r;
                mul_y = ad_r;
                mul_go = 1'b1;
                phase_nxt = PH_PD;
              end
              PH_PD: begin
                t2_nxt = mul_p;
                e_nxt = e_r - EW'(1);
                if (e_r == EW'(1)) begin
                  xn_nxt = t1_r;
                  xd_nxt = mul_p;
                  phase_nxt = PH_RES;
                  state_nxt = S_NORM;
                end else begin
                  mul_x = t1_r;
                  mul_y = an_r;
                  mul_go = 1'b1;
                  phase_nxt = PH_PN;
                end
              end
              default: begin
                fin = 1'b1;
                fin_st = ST_APPROX;
              end
            endcase
          end
        end
      end

      // root ready
      S_SQRT: begin
        if (sq_done) begin
          if (!sq_exact) begin
            fin = 1'b1;
            fin_st = ST_APPROX;
          end else if (phase_r == PH_SQN) begin
            t1_nxt = sq_div;
            sq_x = $unsigned(ad_r);
            sq_go = 1'b1;
            phase_nxt = PH_SQD;
          end else begin
            xn_nxt = t1_r;
            xd_nxt = sq_div;
            phase_nxt = PH_RES;
            state_nxt = S_NORM;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // result register load
    if (fin) begin
      state_nxt = S_IDLE;
      strobe_nxt = 1'b1;
      ost_nxt = fin_st;
      if (fin_st == ST_OK) begin
        onum_nxt = fin_n;
        oden_nxt = fin_d;
      end else begin
        onum_nxt = '0;
        oden_nxt = ONE_W;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;
    cmd_r <= cmd_nxt;
    an_r <= an_nxt;
    ad_r <= ad_nxt;
    bn_r <= bn_nxt;
    bd_r <= bd_nxt;
    t1_r <= t1_nxt;
    t2_r <= t2_nxt;
    xn_r <= xn_nxt;
    xd_r <= xd_nxt;
    g_r <= g_nxt;
    e_r <= e_nxt;
    pneg_r <= pneg_nxt;
    onum_r <= onum_nxt;
    oden_r <= oden_nxt;
    ost_r <= ost_nxt;
  end

  // shared engines
  erat_mul #(.W(W)) u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (mul_go),
    .x    (mul_x),
    .y    (mul_y),
    .done (mul_done),
    .p    (mul_p),
    .ovf  (mul_ovf)
  );

  erat_div #(.W(W)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (div_go),
    .n    (div_n),
    .d    (div_d),
    .done (div_done),
    .q    (div_q)
  );

  erat_gcd #(.W(W)) u_gcd (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (gcd_go),
    .u    (gcd_u),
    .v    (gcd_v),
    .done (gcd_done),
    .g    (gcd_g)
  );

  erat_isqrt #(.W(W)) u_isqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (sq_go),
    .x    (sq_x),
    .done (sq_done),
    .root (sq_root),
    .exact(sq_exact)
  );

  assign busy = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_r_num = 64'(onum_r);
  assign out_r_den = 63'($unsigned(oden_r));
  assign out_status = ost_r;

endmodule

`default_nettype wire

>>> rtl/core/erat_chk.sv
// port-level checks for the exact rational unit, bound to the top level
`default_nettype none

module erat_chk import erat_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_strobe,
  input wire logic signed [63:0] out_r_num,
  input wire logic [62:0]        out_r_den,
  input wire logic [1:0]         out_status
);

  // a failed item carries the neutral value 0/1
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status != ST_OK) |-> (out_r_num == '0) && (out_r_den == 63'd1))
    else $error("non-exact result without 0/1 value");

  // an exact result never has a zero denominator
  a_den_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status == ST_OK) |-> (out_r_den != '0))
    else $error("exact result with zero denominator");

  // an accepted item either starts working or finishes at once
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_strobe)
    else $error("accepted item neither running nor finished");

  // the end of a busy period always delivers a result
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_strobe)
    else $error("item ended without a result");

endmodule

bind exact_rational_alu_top erat_chk u_erat_chk (.*);

`default_nettype wire
